/* hdl/dqe_pkg.sv */
`timescale 1ns / 1ps

package dqe_pkg;

   localparam int LABEL_CAPACITY = 32;
   localparam int CNT_W          = $clog2(LABEL_CAPACITY + 1);
   localparam int ADDR_W         = (LABEL_CAPACITY > 1) ? $clog2(LABEL_CAPACITY) : 1;
   localparam int RAM_DEPTH      = 1 << ADDR_W;
   localparam int STEP_W         = (CNT_W > 4) ? CNT_W : 4;
   localparam int HDR_BYTES      = 12;
   localparam int TAIL_BYTES     = 4;

   localparam logic [7:0] CHAR_DOT = 8'h2E;
   localparam logic [7:0] CHAR_END = 8'h00;

   localparam logic [1:0] CSR_TXN_ID = 2'd0;
   localparam logic [1:0] CSR_FLAGS  = 2'd1;
   localparam logic [1:0] CSR_QTYPE  = 2'd2;
   localparam logic [1:0] CSR_QCLASS = 2'd3;

   localparam logic [15:0] TXN_ID_RESET = 16'h0000;
   localparam logic [15:0] FLAGS_RESET  = 16'h0100;
   localparam logic [15:0] QTYPE_RESET  = 16'h0001;
   localparam logic [15:0] QCLASS_RESET = 16'h0001;

   typedef struct packed {
      logic [15:0] txn_id;
      logic [15:0] flags;
      logic [15:0] qtype;
      logic [15:0] qclass;
   } dqe_cfg_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic [ADDR_W-1:0] rd_addr;
   } dqe_ram_req_type;

   function automatic logic [7:0] header_byte(input logic [STEP_W-1:0] idx,
                                              input dqe_cfg_type cfg);
      logic [7:0] b;
      case (idx)
         STEP_W'(0): b = cfg.txn_id[15:8];
         STEP_W'(1): b = cfg.txn_id[7:0];
         STEP_W'(2): b = cfg.flags[15:8];
         STEP_W'(3): b = cfg.flags[7:0];
         STEP_W'(5): b = 8'h01;
         default:    b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] tail_byte(input logic [1:0] idx, input dqe_cfg_type cfg);
      logic [7:0] b;
      case (idx)
         2'd0:    b = cfg.qtype[15:8];
         2'd1:    b = cfg.qtype[7:0];
         2'd2:    b = cfg.qclass[15:8];
         default: b = cfg.qclass[7:0];
      endcase
      return b;
   endfunction

endpackage

/* hdl/dqe_ifs.sv */
`timescale 1ns / 1ps

interface dqe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] name_char;

   modport source (output valid, output name_char, input ready);
   modport sink   (input valid, input name_char, output ready);
endinterface

interface dqe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       message_end;
   logic       label_overflow;

   modport source (output valid, output out_byte, output run_last, output message_end,
                   output label_overflow, input ready);
   modport sink   (input valid, input out_byte, input run_last, input message_end,
                   input label_overflow, output ready);
endinterface

/* hdl/dqe_label_ram.sv */
`timescale 1ns / 1ps

module dqe_label_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 8,
   parameter int AW    = 5
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/dqe_sequencer.sv */
`timescale 1ns / 1ps

module dqe_sequencer
   import dqe_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   dqe_req_if.sink         req,
   dqe_rsp_if.source       rsp,
   input  dqe_cfg_type     cfg,
   output dqe_ram_req_type ram_req,
   input  logic [7:0]      ram_rd_data
);

   typedef enum logic [2:0] {S_IDLE, S_HDR, S_LEN, S_DATA, S_ROOT, S_TAIL} state_type;
   typedef enum logic [1:0] {K_CHAR, K_DOT, K_END} kind_type;

   localparam logic [STEP_W-1:0] HDR_LAST  = STEP_W'(HDR_BYTES - 1);
   localparam logic [STEP_W-1:0] TAIL_LAST = STEP_W'(TAIL_BYTES - 1);
   localparam logic [CNT_W-1:0]  CAP       = CNT_W'(LABEL_CAPACITY);

   state_type         state_ff, state_in;
   kind_type          kind_ff, kind_in, kind_acc;
   logic [STEP_W-1:0] cnt_ff, cnt_in, cnt_last;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic              hdr_sent_ff, hdr_sent_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        byte_ff, byte_in;
   logic              run_last_ff, run_last_in;
   logic              msg_end_ff, msg_end_in;
   logic              lovf_ff, lovf_in;

   logic              slot_free, accept, emit;
   logic [7:0]        e_byte;
   logic              e_last, e_end, e_ovf;

   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign cnt_last  = STEP_W'(count_ff) - STEP_W'(1);

   always_comb begin
      if (req.name_char == CHAR_DOT) begin
         kind_acc = K_DOT;
      end else if (req.name_char == CHAR_END) begin
         kind_acc = K_END;
      end else begin
         kind_acc = K_CHAR;
      end
   end

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      cnt_in      = cnt_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      hdr_sent_in = hdr_sent_ff;
      emit        = 1'b0;
      e_byte      = 8'h00;
      e_last      = 1'b0;
      e_end       = 1'b0;
      e_ovf       = 1'b0;
      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = count_ff[ADDR_W-1:0];
      ram_req.wr_data = req.name_char;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in = kind_acc;
               cnt_in  = '0;
               if (kind_acc == K_CHAR) begin
                  if (count_ff < CAP) begin
                     ram_req.wr_en = 1'b1;
                     count_in      = count_ff + CNT_W'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               if (!hdr_sent_ff) begin
                  state_in    = S_HDR;
                  hdr_sent_in = 1'b1;
               end else if (kind_acc == K_DOT) begin
                  state_in = S_LEN;
               end else if (kind_acc == K_END) begin
                  state_in = (count_ff != '0) ? S_LEN : S_ROOT;
               end
            end
         end
         S_HDR: begin
            if (slot_free) begin
               emit   = 1'b1;
               e_byte = header_byte(cnt_ff, cfg);
               if (cnt_ff == HDR_LAST) begin
                  cnt_in = '0;
                  case (kind_ff)
                     K_DOT:   state_in = S_LEN;
                     K_END:   state_in = (count_ff != '0) ? S_LEN : S_ROOT;
                     default: begin
                        e_last   = 1'b1;
                        state_in = S_IDLE;
                     end
                  endcase
               end else begin
                  cnt_in = cnt_ff + STEP_W'(1);
               end
            end
         end
         S_LEN: begin
            if (slot_free) begin
               emit   = 1'b1;
               e_byte = 8'(count_ff);
               e_ovf  = ovf_ff;
               cnt_in = '0;
               if (count_ff == '0) begin
                  e_last   = 1'b1;
                  ovf_in   = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_DATA;
               end
            end
         end
         S_DATA: begin
            if (slot_free) begin
               emit   = 1'b1;
               e_byte = ram_rd_data;
               e_ovf  = ovf_ff;
               if (cnt_ff == cnt_last) begin
                  cnt_in   = '0;
                  count_in = '0;
                  ovf_in   = 1'b0;
                  if (kind_ff == K_DOT) begin
                     e_last   = 1'b1;
                     state_in = S_IDLE;
                  end else begin
                     state_in = S_ROOT;
                  end
               end else begin
                  cnt_in = cnt_ff + STEP_W'(1);
               end
            end
         end
         S_ROOT: begin
            if (slot_free) begin
               emit     = 1'b1;
               cnt_in   = '0;
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            if (slot_free) begin
               emit   = 1'b1;
               e_byte = tail_byte(cnt_ff[1:0], cfg);
               if (cnt_ff == TAIL_LAST) begin
                  e_last      = 1'b1;
                  e_end       = 1'b1;
                  cnt_in      = '0;
                  hdr_sent_in = 1'b0;
                  state_in    = S_IDLE;
               end else begin
                  cnt_in = cnt_ff + STEP_W'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      ram_req.rd_addr = cnt_in[ADDR_W-1:0];
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      byte_in      = byte_ff;
      run_last_in  = run_last_ff;
      msg_end_in   = msg_end_ff;
      lovf_in      = lovf_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         byte_in      = e_byte;
         run_last_in  = e_last;
         msg_end_in   = e_end;
         lovf_in      = e_ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         kind_ff      <= K_CHAR;
         cnt_ff       <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         hdr_sent_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         cnt_ff       <= cnt_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         hdr_sent_ff  <= hdr_sent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      byte_ff     <= byte_in;
      run_last_ff <= run_last_in;
      msg_end_ff  <= msg_end_in;
      lovf_ff     <= lovf_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.out_byte       = byte_ff;
   assign rsp.run_last       = run_last_ff;
   assign rsp.message_end    = msg_end_ff;
   assign rsp.label_overflow = lovf_ff;

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && msg_end_ff |-> run_last_ff)
      else $error("message end without run end");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP)
      else $error("label count beyond capacity");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> count_ff == CAP)
      else $error("overflow flag with label not full");

   a_data_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DATA |-> count_ff != '0)
      else $error("label readout with empty label");

endmodule

/* hdl/dns_query_encoder_core.sv */
`timescale 1ns / 1ps
// channel  | port          | dir | payload
// ---------+---------------+-----+--------------------------------------------------
// request  | req           | in  | name_char
// response | rsp           | out | out_byte, run_last, message_end, label_overflow
// csr      | csr_wr_en ... | in  | csr_index selects register, csr_wdata value
//
// An ordinary character after the header is taken without leaving idle; req.ready stays high.
// Other items hold req.ready low while their bytes go out through the output register, one
// byte per cycle while rsp is not stalled: 12 header bytes, then length byte plus n label
// bytes, then 5 closing bytes. Label bytes come from a one-port-write, one-port-read RAM
// with a registered read port. Reset is synchronous and clears control state; label RAM
// contents stay. A stalled rsp holds the output register and any state that sends bytes.

module dns_query_encoder_core
   import dqe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   dqe_req_if.sink     req,
   dqe_rsp_if.source   rsp,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   dqe_cfg_type     cfg_ff, cfg_in;
   dqe_ram_req_type ram_req;
   logic [7:0]      ram_rd_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_TXN_ID: cfg_in.txn_id = csr_wdata;
            CSR_FLAGS:  cfg_in.flags  = csr_wdata;
            CSR_QTYPE:  cfg_in.qtype  = csr_wdata;
            CSR_QCLASS: cfg_in.qclass = csr_wdata;
            default:    cfg_in        = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.txn_id <= TXN_ID_RESET;
         cfg_ff.flags  <= FLAGS_RESET;
         cfg_ff.qtype  <= QTYPE_RESET;
         cfg_ff.qclass <= QCLASS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dqe_label_ram #(
      .DEPTH (RAM_DEPTH),
      .WIDTH (8),
      .AW    (ADDR_W)
   ) u_label_ram (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_data)
   );

   dqe_sequencer u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .cfg         (cfg_ff),
      .ram_req     (ram_req),
      .ram_rd_data (ram_rd_data)
   );

endmodule
